@@ design/bbc_pkg.sv @@
// Shared types and constants for the bounding box centering core.
package bbc_pkg;

  localparam int unsigned POINT_DEPTH_DEF = 64;

  localparam logic [1:0] KIND_OUTLINE = 2'd0;
  localparam logic [1:0] KIND_CIRCLE  = 2'd1;

  localparam logic signed [32:0] BOX_POS_MAX = {1'b0, {32{1'b1}}};
  localparam logic signed [32:0] BOX_NEG_MIN = {1'b1, {32{1'b0}}};

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [30:0]        radius;
    logic               final_item;
  } bbc_in_t;

  typedef struct packed {
    logic signed [31:0] shifted_x;
    logic signed [31:0] shifted_y;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic               dropped;
    logic               run_end;
  } bbc_out_t;

  typedef struct packed {
    logic upd;
    logic clr;
  } bbc_box_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CENTRE,
    ST_REPLAY
  } bbc_state_e;

endpackage

@@ design/bbc_mem.sv @@
// Point store: one write port, one registered read port.
module bbc_mem import bbc_pkg::*; #(
  parameter int unsigned POINT_DEPTH = POINT_DEPTH_DEF,
  parameter int unsigned AW          = $clog2(POINT_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [POINT_DEPTH];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bbc_box.sv @@
// Running bounding box and centre offset computation.
module bbc_box import bbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbc_box_ctrl_t      ctrl_i,
  input  bbc_in_t            pt_i,
  output logic signed [31:0] centre_x_o,
  output logic signed [31:0] centre_y_o
);

  logic signed [32:0] min_x_q, min_x_d, max_x_q, max_x_d;
  logic signed [32:0] min_y_q, min_y_d, max_y_q, max_y_d;
  logic               seen_q, seen_d;
  logic signed [32:0] x33, y33, r33;
  logic signed [32:0] lo_x, hi_x, lo_y, hi_y;
  logic               widen;
  logic signed [33:0] sum_x, sum_y, half_x, half_y;

  always_comb begin
    x33 = {pt_i.coord_x[31], pt_i.coord_x};
    y33 = {pt_i.coord_y[31], pt_i.coord_y};
    r33 = (pt_i.kind == KIND_CIRCLE) ? {2'b00, pt_i.radius} : 33'sd0;
    lo_x = x33 - r33;
    hi_x = x33 + r33;
    lo_y = y33 - r33;
    hi_y = y33 + r33;
    widen = ctrl_i.upd && (pt_i.kind == KIND_OUTLINE || pt_i.kind == KIND_CIRCLE);

    min_x_d = min_x_q;
    max_x_d = max_x_q;
    min_y_d = min_y_q;
    max_y_d = max_y_q;
    seen_d  = seen_q;
    if (ctrl_i.clr) begin
      min_x_d = BOX_POS_MAX;
      min_y_d = BOX_POS_MAX;
      max_x_d = BOX_NEG_MIN;
      max_y_d = BOX_NEG_MIN;
      seen_d  = 1'b0;
    end else if (widen) begin
      if (lo_x < min_x_q) min_x_d = lo_x;
      if (hi_x > max_x_q) max_x_d = hi_x;
      if (lo_y < min_y_q) min_y_d = lo_y;
      if (hi_y > max_y_q) max_y_d = hi_y;
      seen_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= BOX_POS_MAX;
      min_y_q <= BOX_POS_MAX;
      max_x_q <= BOX_NEG_MIN;
      max_y_q <= BOX_NEG_MIN;
      seen_q  <= 1'b0;
    end else begin
      min_x_q <= min_x_d;
      min_y_q <= min_y_d;
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
      seen_q  <= seen_d;
    end
  end

  // (min + max) / 2 rounded toward zero
  always_comb begin
    sum_x  = {min_x_q[32], min_x_q} + {max_x_q[32], max_x_q};
    sum_y  = {min_y_q[32], min_y_q} + {max_y_q[32], max_y_q};
    half_x = (sum_x + {33'd0, sum_x[33]}) >>> 1;
    half_y = (sum_y + {33'd0, sum_y[33]}) >>> 1;
    centre_x_o = seen_q ? half_x[31:0] : 32'sd0;
    centre_y_o = seen_q ? half_y[31:0] : 32'sd0;
  end

endmodule

@@ design/bounding_box_centering_core.sv @@
// Top level: point load, centre capture and replay through the point store.
// Load: one point per cycle while ready; points go to the store while it has room.
// After the final point, the centre is captured once any pending read has drained,
// then the store read port replays one result per cycle unless the output stalls.
// Input waits during centre capture and replay.
// Reset (async, active low) clears control, count and box; the store is not cleared.
module bounding_box_centering_core import bbc_pkg::*; #(
  parameter int unsigned POINT_DEPTH = POINT_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bbc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bbc_out_t out_data_o
);

  localparam int unsigned AW = $clog2(POINT_DEPTH);
  localparam int unsigned CW = $clog2(POINT_DEPTH + 1);

  bbc_state_e         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic               ovf_q, ovf_d;
  logic               drop_q;
  logic [AW-1:0]      last_q, rd_addr_q;
  logic               rd_pend_q, rd_last_q;
  logic signed [31:0] cx_q, cy_q, box_cx, box_cy;
  logic               out_valid_q;
  bbc_out_t           out_q;
  logic               in_fire, store_ok, centre_ld, advance, rd_issue, out_ld;
  logic [CW-1:0]      count_m1;
  logic [63:0]        rdata;
  bbc_box_ctrl_t      box_ctrl;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign store_ok   = count_q < CW'(POINT_DEPTH);
  assign advance    = !out_valid_q || out_ready_i;
  assign rd_issue   = (state_q == ST_REPLAY) && (!rd_pend_q || advance);
  assign out_ld     = rd_pend_q && advance;
  assign count_m1   = count_q - CW'(1);

  always_comb begin
    state_d   = state_q;
    centre_ld = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire && in_data_i.final_item) state_d = ST_CENTRE;
      end
      ST_CENTRE: begin
        if (!rd_pend_q) begin
          centre_ld = 1'b1;
          state_d   = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (rd_issue && rd_addr_q == last_q) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (centre_ld) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (in_fire) begin
      if (store_ok) count_d = count_q + CW'(1);
      else          ovf_d   = 1'b1;
    end
  end

  assign box_ctrl.upd = in_fire;
  assign box_ctrl.clr = centre_ld;

  bbc_box u_box (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (box_ctrl),
    .pt_i       (in_data_i),
    .centre_x_o (box_cx),
    .centre_y_o (box_cy)
  );

  bbc_mem #(
    .POINT_DEPTH (POINT_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (in_fire && store_ok),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({in_data_i.coord_y, in_data_i.coord_x}),
    .re_i    (rd_issue),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      rd_pend_q   <= rd_issue || (rd_pend_q && !advance);
      if (out_ld)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (centre_ld) begin
      cx_q      <= box_cx;
      cy_q      <= box_cy;
      drop_q    <= ovf_q;
      last_q    <= count_m1[AW-1:0];
      rd_addr_q <= '0;
    end else if (rd_issue) begin
      rd_addr_q <= rd_addr_q + AW'(1);
    end
    if (rd_issue) rd_last_q <= (rd_addr_q == last_q);
    if (out_ld) begin
      out_q.shifted_x <= rdata[31:0] - cx_q;
      out_q.shifted_y <= rdata[63:32] - cy_q;
      out_q.centre_x  <= cx_q;
      out_q.centre_y  <= cy_q;
      out_q.dropped   <= drop_q;
      out_q.run_end   <= rd_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for bounding_box_centering_core: random footprints, box and centre predictor.
module tb;
  import bbc_pkg::*;

  localparam logic [1:0]  KIND_MOVE   = 2'd2;
  localparam logic [1:0]  KIND_SPARE  = 2'd3;
  localparam logic [31:0] COORD_MIN   = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX   = 32'h7fff_ffff;
  localparam logic [30:0] RADIUS_MAX  = 31'h7fff_ffff;
  localparam int          ITEM_TARGET = 500;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  bbc_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  bbc_out_t out_data_o;

  bounding_box_centering_core #(.POINT_DEPTH(POINT_DEPTH_DEF)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  bbc_in_t     point_feed_q[$];
  bbc_out_t    centred_q[$];
  int          mismatch_cnt = 0;
  int          cyc = 0;
  int          item_cnt = 0;

  // predicted footprint state
  longint      box_lo_x = BOX_POS_MAX;
  longint      box_lo_y = BOX_POS_MAX;
  longint      box_hi_x = BOX_NEG_MIN;
  longint      box_hi_y = BOX_NEG_MIN;
  bit          box_any = 1'b0;
  bit          lost_any = 1'b0;
  logic [31:0] held_x[$];
  logic [31:0] held_y[$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic bit idle_now();
    if ((cyc % 2000) >= 400 && (cyc % 2000) < 900) return 1'b0;
    return $urandom_range(99, 0) < 13;
  endfunction

  task automatic absorb_point(bbc_in_t p);
    longint   x, y, rr, ox, oy;
    logic [31:0] cx, cy;
    bbc_out_t res;
    x = longint'($signed(p.coord_x));
    y = longint'($signed(p.coord_y));
    if (p.kind == KIND_OUTLINE || p.kind == KIND_CIRCLE) begin
      rr = (p.kind == KIND_CIRCLE) ? longint'(p.radius) : 0;
      if (x - rr < box_lo_x) box_lo_x = x - rr;
      if (x + rr > box_hi_x) box_hi_x = x + rr;
      if (y - rr < box_lo_y) box_lo_y = y - rr;
      if (y + rr > box_hi_y) box_hi_y = y + rr;
      box_any = 1'b1;
    end
    if (held_x.size() < POINT_DEPTH_DEF) begin
      held_x.push_back(p.coord_x);
      held_y.push_back(p.coord_y);
    end else begin
      lost_any = 1'b1;
    end
    if (p.final_item) begin
      cx = '0;
      cy = '0;
      if (box_any) begin
        ox = (box_lo_x + box_hi_x) / 2;
        oy = (box_lo_y + box_hi_y) / 2;
        cx = ox[31:0];
        cy = oy[31:0];
      end
      for (int k = 0; k < held_x.size(); k++) begin
        res.shifted_x = held_x[k] - cx;
        res.shifted_y = held_y[k] - cy;
        res.centre_x  = cx;
        res.centre_y  = cy;
        res.dropped   = lost_any;
        res.run_end   = (k == held_x.size() - 1);
        centred_q.push_back(res);
      end
      held_x.delete();
      held_y.delete();
      box_lo_x = BOX_POS_MAX;
      box_lo_y = BOX_POS_MAX;
      box_hi_x = BOX_NEG_MIN;
      box_hi_y = BOX_NEG_MIN;
      box_any  = 1'b0;
      lost_any = 1'b0;
    end
  endtask

  task automatic queue_point(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
                             logic [30:0] r, logic fin);
    bbc_in_t p;
    p.kind       = kind;
    p.coord_x    = x;
    p.coord_y    = y;
    p.radius     = r;
    p.final_item = fin;
    point_feed_q.push_back(p);
    item_cnt++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7, 0))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 32'($urandom_range(2000, 0)) - 32'd1000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] rand_kind();
    int pick;
    pick = $urandom_range(9, 0);
    if (pick < 5) return KIND_OUTLINE;
    if (pick < 7) return KIND_CIRCLE;
    if (pick < 9) return KIND_MOVE;
    return KIND_SPARE;
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(7, 0))
      0: return RADIUS_MAX;
      1: return '0;
      2, 3: return 31'($urandom_range(1000, 0));
      default: return 31'($urandom());
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) absorb_point(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (point_feed_q.size() != 0 && !idle_now()) begin
          in_data_i  <= point_feed_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor
  bbc_out_t want_res;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (centred_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t unexpected transaction: actual %h", $time, out_data_o);
        end else begin
          want_res = centred_q.pop_front();
          check_field("shifted_x", want_res.shifted_x, out_data_o.shifted_x);
          check_field("shifted_y", want_res.shifted_y, out_data_o.shifted_y);
          check_field("centre_x", want_res.centre_x, out_data_o.centre_x);
          check_field("centre_y", want_res.centre_y, out_data_o.centre_y);
          check_field("dropped", 32'(want_res.dropped), 32'(out_data_o.dropped));
          check_field("run_end", 32'(want_res.run_end), 32'(out_data_o.run_end));
        end
      end
      out_ready_i <= !idle_now();
    end
  end

  initial begin
    int len;
    // extremes cancel to a zero centre
    queue_point(KIND_OUTLINE, COORD_MAX, COORD_MAX, RADIUS_MAX, 1'b0);
    queue_point(KIND_OUTLINE, COORD_MIN, COORD_MIN, RADIUS_MAX, 1'b1);
    // widest circle
    queue_point(KIND_CIRCLE, COORD_MAX, COORD_MIN, RADIUS_MAX, 1'b1);
    // box sum beyond 32 bits, positive then negative
    queue_point(KIND_OUTLINE, COORD_MAX, COORD_MAX, '0, 1'b0);
    queue_point(KIND_CIRCLE, COORD_MAX, COORD_MAX, RADIUS_MAX, 1'b1);
    queue_point(KIND_OUTLINE, COORD_MIN, COORD_MIN, '0, 1'b0);
    queue_point(KIND_CIRCLE, COORD_MIN, COORD_MIN, RADIUS_MAX, 1'b1);
    // empty box: translate-only and the unused kind
    queue_point(KIND_MOVE, 32'd12345, -32'sd777, RADIUS_MAX, 1'b0);
    queue_point(KIND_SPARE, COORD_MIN, COORD_MAX, RADIUS_MAX, 1'b0);
    queue_point(KIND_MOVE, COORD_MAX, COORD_MIN, '0, 1'b1);
    // single point
    queue_point(KIND_OUTLINE, -32'sd3, 32'd5, '0, 1'b1);
    // zero radius circle, odd negative sum
    queue_point(KIND_CIRCLE, -32'sd7, -32'sd1, '0, 1'b0);
    queue_point(KIND_OUTLINE, -32'sd2, 32'd0, '0, 1'b1);
    // mixed kinds, unused kind closes the run
    queue_point(KIND_OUTLINE, 32'd100, 32'd200, RADIUS_MAX, 1'b0);
    queue_point(KIND_MOVE, 32'd5000, -32'sd5000, '0, 1'b0);
    queue_point(KIND_CIRCLE, -32'sd50, 32'd60, 31'd25, 1'b0);
    queue_point(KIND_SPARE, COORD_MAX, COORD_MAX, '0, 1'b0);
    queue_point(KIND_OUTLINE, 32'd1, -32'sd1, '0, 1'b0);
    queue_point(KIND_SPARE, 32'd9, 32'd9, RADIUS_MAX, 1'b1);

    len = 70;
    while (item_cnt < ITEM_TARGET) begin
      for (int i = 0; i < len; i++)
        queue_point(rand_kind(), rand_coord(), rand_coord(), rand_radius(), i == len - 1);
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(72, 60) : $urandom_range(8, 1);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (point_feed_q.size() != 0 || in_valid_i || centred_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && centred_q.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
